// ===== rtl/particle_euler_step_defines.svh =====
// Assertion macros for the particle step block.
// Used by the top level only; needs nothing else.
`ifndef PARTICLE_EULER_STEP_DEFINES_SVH
`define PARTICLE_EULER_STEP_DEFINES_SVH

// Implication checked in the same cycle.
`define PE_ASSERT_IMP(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// Implication checked in the next cycle.
`define PE_ASSERT_NXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

// ===== rtl/pe_pkg.sv =====
// Shared types and constants for the particle step pipeline.
// No dependencies.
package pe_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int RATIO_BITS      = 16;
  localparam int AGE_W           = 31;
  localparam int FIELD_W         = 32;
  localparam int CFG_IDX_W       = 3;
  localparam int MOTION_LAT      = 4;
  localparam int DIV_LAT         = RATIO_BITS;
  localparam int BLEND_LAT       = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRAV_X      = 3'd0,
    REG_GRAV_Y      = 3'd1,
    REG_GRAV_Z      = 3'd2,
    REG_COLOR_START = 3'd3,
    REG_COLOR_END   = 3'd4,
    REG_SIZE_START  = 3'd5,
    REG_SIZE_END    = 3'd6
  } pe_reg_e;

  // Record handed to the motion unit.
  typedef struct packed {
    logic                          live;
    logic [AGE_W-1:0]              age;
    logic [AGE_W-1:0]              dt;
    logic [2:0][FIELD_W-1:0]       vel;
    logic [2:0][FIELD_W-1:0]       pos;
  } pe_rec_t;

  // Motion unit result.
  typedef struct packed {
    logic                          live;
    logic [AGE_W-1:0]              age;
    logic [2:0][FIELD_W-1:0]       vel;
    logic [2:0][FIELD_W-1:0]       pos;
  } pe_mot_t;

endpackage

// ===== rtl/pe_motion.sv =====
// Four-stage semi-implicit Euler update with saturation.
// Depends on pe_pkg.
module pe_motion #(
  parameter int COORD_WIDTH = pe_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = pe_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    en,
  input  logic [2:0][pe_pkg::FIELD_W-1:0]         grav,
  input  pe_pkg::pe_rec_t                         rec,
  output pe_pkg::pe_mot_t                         res
);
  import pe_pkg::*;

  localparam int SAT_W = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
  localparam logic signed [64:0] SAT_HI = (65'sd1 <<< (SAT_W - 1)) - 65'sd1;
  localparam logic signed [64:0] SAT_LO = -SAT_HI - 65'sd1;

  function automatic logic [FIELD_W-1:0] sat_add(input logic [FIELD_W-1:0] a,
                                                 input logic [63:0] p);
    logic signed [64:0] s;
    logic signed [63:0] sh;
    begin
      sh = $signed(p) >>> FRAC_BITS;
      s  = $signed({{33{a[31]}}, a}) + $signed({sh[63], sh});
      if (s > SAT_HI) s = SAT_HI;
      else if (s < SAT_LO) s = SAT_LO;
      sat_add = s[FIELD_W-1:0];
    end
  endfunction

  pe_rec_t                    m1_rec_r, m2_rec_r, m3_rec_r;
  logic [2:0][63:0]           m1_prod_r, m3_prod_r;
  pe_mot_t                    m4_res_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m1_rec_r <= rec;
      for (int i = 0; i < 3; i++) begin
        m1_prod_r[i] <= $signed(grav[i]) * $signed({1'b0, rec.dt});
      end
      m2_rec_r.live <= m1_rec_r.live;
      m2_rec_r.age  <= m1_rec_r.age;
      m2_rec_r.dt   <= m1_rec_r.dt;
      m2_rec_r.pos  <= m1_rec_r.pos;
      for (int i = 0; i < 3; i++) begin
        m2_rec_r.vel[i] <= m1_rec_r.live ? sat_add(m1_rec_r.vel[i], m1_prod_r[i])
                                         : m1_rec_r.vel[i];
      end
      m3_rec_r <= m2_rec_r;
      for (int i = 0; i < 3; i++) begin
        m3_prod_r[i] <= $signed(m2_rec_r.vel[i]) * $signed({1'b0, m2_rec_r.dt});
      end
      m4_res_r.live <= m3_rec_r.live;
      m4_res_r.age  <= m3_rec_r.age;
      m4_res_r.vel  <= m3_rec_r.vel;
      for (int i = 0; i < 3; i++) begin
        m4_res_r.pos[i] <= m3_rec_r.live ? sat_add(m3_rec_r.pos[i], m3_prod_r[i])
                                         : m3_rec_r.pos[i];
      end
    end
  end

  assign res = m4_res_r;

endmodule

// ===== rtl/pe_div.sv =====
// Pipelined restoring divider: floor(age * 2^16 / life), one quotient bit a stage.
// Depends on pe_pkg. Result is meaningful only while age < life.
module pe_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [pe_pkg::AGE_W-1:0]      age,
  input  logic [pe_pkg::AGE_W-1:0]      life,
  output logic [pe_pkg::RATIO_BITS-1:0] ratio
);
  import pe_pkg::*;

  logic [AGE_W-1:0]      rem_r  [DIV_LAT];
  logic [AGE_W-1:0]      life_r [DIV_LAT];
  logic [RATIO_BITS-1:0] quo_r  [DIV_LAT];

  for (genvar k = 0; k < DIV_LAT; k++) begin : g_stage
    logic [AGE_W-1:0]      rem_in, life_in;
    logic [RATIO_BITS-1:0] quo_in;
    logic [AGE_W:0]        trial;
    logic                  take;

    if (k == 0) begin : g_first
      assign rem_in  = age;
      assign life_in = life;
      assign quo_in  = '0;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign life_in = life_r[k-1];
      assign quo_in  = quo_r[k-1];
    end

    assign trial = {rem_in, 1'b0};
    assign take  = trial >= {1'b0, life_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= take ? AGE_W'(trial - {1'b0, life_in}) : trial[AGE_W-1:0];
        life_r[k] <= life_in;
        quo_r[k]  <= {quo_in[RATIO_BITS-2:0], take};
      end
    end
  end

  assign ratio = quo_r[DIV_LAT-1];

endmodule

// ===== rtl/pe_blend.sv =====
// Linear colour and size interpolation by the life ratio, one register stage.
// Depends on pe_pkg.
module pe_blend (
  input  logic                          clk,
  input  logic                          en,
  input  logic [pe_pkg::RATIO_BITS-1:0] ratio,
  input  logic [31:0]                   color_start,
  input  logic [31:0]                   color_end,
  input  logic [15:0]                   size_start,
  input  logic [15:0]                   size_end,
  output logic [pe_pkg::RATIO_BITS-1:0] ratio_out,
  output logic [31:0]                   color,
  output logic [15:0]                   size
);
  import pe_pkg::*;

  logic [31:0]           color_nxt, color_r;
  logic [15:0]           size_nxt, size_r;
  logic [RATIO_BITS-1:0] ratio_r;
  logic signed [8:0]     cd   [4];
  logic signed [25:0]    cp   [4];
  logic signed [16:0]    sd;
  logic signed [33:0]    sp;

  // Only the low bits of the floored product matter after the wrap to channel width.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cd[i] = $signed({1'b0, color_end[8*i +: 8]}) - $signed({1'b0, color_start[8*i +: 8]});
      cp[i] = cd[i] * $signed({1'b0, ratio});
      color_nxt[8*i +: 8] = color_start[8*i +: 8] + cp[i][23:16];
    end
    sd       = $signed({1'b0, size_end}) - $signed({1'b0, size_start});
    sp       = sd * $signed({1'b0, ratio});
    size_nxt = size_start + sp[31:16];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      color_r <= color_nxt;
      size_r  <= size_nxt;
      ratio_r <= ratio;
    end
  end

  assign color     = color_r;
  assign size      = size_r;
  assign ratio_out = ratio_r;

endmodule

// ===== rtl/particle_euler_step.sv =====
// Particle step pipeline: takes one particle record per cycle unless stalled and delivers
// its result after the age stage, the 16-stage life-ratio divider and the blend stage,
// with the motion unit delayed to line up. A stall on the result side while a result is
// valid freezes the whole pipeline and is passed back to the input at once.
// Configuration is always ready; write it only while the pipeline is empty.
`include "particle_euler_step_defines.svh"
module particle_euler_step #(
  parameter int COORD_WIDTH = pe_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = pe_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_alive_in,
  input  logic [30:0]                   in_age_in,
  input  logic [30:0]                   in_lifetime_in,
  input  logic signed [31:0]            in_vel_x_in,
  input  logic signed [31:0]            in_vel_y_in,
  input  logic signed [31:0]            in_vel_z_in,
  input  logic signed [31:0]            in_pos_x_in,
  input  logic signed [31:0]            in_pos_y_in,
  input  logic signed [31:0]            in_pos_z_in,
  input  logic [30:0]                   in_delta_time,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_alive_out,
  output logic [30:0]                   out_age_out,
  output logic signed [31:0]            out_vel_x_out,
  output logic signed [31:0]            out_vel_y_out,
  output logic signed [31:0]            out_vel_z_out,
  output logic signed [31:0]            out_pos_x_out,
  output logic signed [31:0]            out_pos_y_out,
  output logic signed [31:0]            out_pos_z_out,
  output logic [15:0]                   out_life_ratio,
  output logic [31:0]                   out_color_out,
  output logic [15:0]                   out_size_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                   cfg_data
);
  import pe_pkg::*;

  localparam int PIPE_LAT = 1 + DIV_LAT + BLEND_LAT;
  localparam int ALIGN    = DIV_LAT + BLEND_LAT - MOTION_LAT;

  logic                    en;
  logic [2:0][31:0]        grav_r;
  logic [31:0]             color_start_r, color_end_r;
  logic [15:0]             size_start_r, size_end_r;
  logic [PIPE_LAT-1:0]     vld_r;
  pe_rec_t                 s1_rec_nxt, s1_rec_r;
  logic [AGE_W-1:0]        s1_life_r;
  logic [AGE_W:0]          age_sum;
  logic [AGE_W-1:0]        age_new;
  pe_rec_t                 dly_r [ALIGN];
  pe_mot_t                 mot;
  logic [RATIO_BITS-1:0]   ratio, ratio_b;
  logic [31:0]             color_b;
  logic [15:0]             size_b;

  // Whole pipeline advances unless a finished result is held back.
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r        <= {32'h0000_0000, 32'hFFFE_0000, 32'h0000_0000};
      color_start_r <= 32'hFFFF_FFFF;
      color_end_r   <= 32'hFFFF_FF00;
      size_start_r  <= 16'd256;
      size_end_r    <= 16'd128;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GRAV_X:      grav_r[0]     <= cfg_data;
        REG_GRAV_Y:      grav_r[1]     <= cfg_data;
        REG_GRAV_Z:      grav_r[2]     <= cfg_data;
        REG_COLOR_START: color_start_r <= cfg_data;
        REG_COLOR_END:   color_end_r   <= cfg_data;
        REG_SIZE_START:  size_start_r  <= cfg_data[15:0];
        REG_SIZE_END:    size_end_r    <= cfg_data[15:0];
        default:         ;
      endcase
    end
  end

  // Age stage: saturating age, deactivate once lifetime is reached.
  always_comb begin
    age_sum          = {1'b0, in_age_in} + {1'b0, in_delta_time};
    age_new          = age_sum[AGE_W] ? {AGE_W{1'b1}} : age_sum[AGE_W-1:0];
    s1_rec_nxt.live  = in_alive_in && (age_new < in_lifetime_in);
    s1_rec_nxt.age   = in_alive_in ? age_new : in_age_in;
    s1_rec_nxt.dt    = in_delta_time;
    s1_rec_nxt.vel   = {in_vel_z_in, in_vel_y_in, in_vel_x_in};
    s1_rec_nxt.pos   = {in_pos_z_in, in_pos_y_in, in_pos_x_in};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_rec_r  <= s1_rec_nxt;
      s1_life_r <= in_lifetime_in;
      dly_r[0]  <= s1_rec_r;
      for (int k = 1; k < ALIGN; k++) begin
        dly_r[k] <= dly_r[k-1];
      end
    end
  end

  pe_div u_div (
    .clk   (clk),
    .en    (en),
    .age   (s1_rec_r.age),
    .life  (s1_life_r),
    .ratio (ratio)
  );

  pe_blend u_blend (
    .clk         (clk),
    .en          (en),
    .ratio       (ratio),
    .color_start (color_start_r),
    .color_end   (color_end_r),
    .size_start  (size_start_r),
    .size_end    (size_end_r),
    .ratio_out   (ratio_b),
    .color       (color_b),
    .size        (size_b)
  );

  pe_motion #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_motion (
    .clk  (clk),
    .en   (en),
    .grav (grav_r),
    .rec  (dly_r[ALIGN-1]),
    .res  (mot)
  );

  assign out_valid      = vld_r[PIPE_LAT-1];
  assign out_alive_out  = mot.live;
  assign out_age_out    = mot.age;
  assign out_vel_x_out  = mot.vel[0];
  assign out_vel_y_out  = mot.vel[1];
  assign out_vel_z_out  = mot.vel[2];
  assign out_pos_x_out  = mot.pos[0];
  assign out_pos_y_out  = mot.pos[1];
  assign out_pos_z_out  = mot.pos[2];
  // Dead or dying particles carry no ratio, colour or size.
  assign out_life_ratio = mot.live ? ratio_b : '0;
  assign out_color_out  = mot.live ? color_b : '0;
  assign out_size_out   = mot.live ? size_b  : '0;

  `PE_ASSERT_IMP(a_dead_blank, clk, rst_n, out_valid && !out_alive_out, out_life_ratio == 16'd0 && out_color_out == 32'd0 && out_size_out == 16'd0, "dead particle carries blend fields")
  `PE_ASSERT_IMP(a_stall_src, clk, rst_n, in_stall, out_valid && out_stall, "input stalled without a held result")
  `PE_ASSERT_NXT(a_hold_res, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_age_out) && $stable(out_pos_x_out), "held result changed")

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for particle_euler_step: random and directed particle records,
// predicted in-bench and compared with every result transfer. Depends on pe_pkg.
module tb_top;
  import pe_pkg::*;

  typedef struct packed {
    logic        alive;
    logic [30:0] age;
    logic [30:0] lifetime;
    logic [31:0] vx, vy, vz, px, py, pz;
    logic [30:0] dt;
  } particle_t;

  typedef struct packed {
    logic        alive;
    logic [30:0] age;
    logic [31:0] vx, vy, vz, px, py, pz;
    logic [15:0] ratio;
    logic [31:0] color;
    logic [15:0] size;
  } step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_alive_in = 1'b0;
  logic [30:0] in_age_in = '0, in_lifetime_in = '0, in_delta_time = '0;
  logic signed [31:0] in_vel_x_in = '0, in_vel_y_in = '0, in_vel_z_in = '0;
  logic signed [31:0] in_pos_x_in = '0, in_pos_y_in = '0, in_pos_z_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_alive_out;
  logic [30:0] out_age_out;
  logic signed [31:0] out_vel_x_out, out_vel_y_out, out_vel_z_out;
  logic signed [31:0] out_pos_x_out, out_pos_y_out, out_pos_z_out;
  logic [15:0] out_life_ratio, out_size_out;
  logic [31:0] out_color_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  particle_euler_step dut (.*);

  always #2 clk = ~clk;

  // Predictor copy of the registers
  logic signed [31:0] grav [3];
  logic [31:0] col_start, col_end;
  logic [15:0] sz_start, sz_end;

  particle_t pending_q[$];
  step_t     expected_q[$];
  int        errors = 0;
  int        send_idle = 21, recv_idle = 70;

  function automatic longint floor_shift(longint a, int sh);
    return a >>> sh;
  endfunction

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint mix(longint s, longint e, longint t);
    return s + floor_shift((e - s) * t, 16);
  endfunction

  function automatic step_t advance_particle(particle_t p);
    step_t r;
    longint agen, t, v, q;
    logic [31:0] vin [3], pin [3], vo [3], po [3];
    vin = '{p.vx, p.vy, p.vz};
    pin = '{p.px, p.py, p.pz};
    r = '0;
    r.age = p.age;
    vo = vin;
    po = pin;
    if (p.alive) begin
      agen = longint'(p.age) + longint'(p.dt);
      if (agen > 64'h7FFFFFFF) agen = 64'h7FFFFFFF;
      r.age = agen[30:0];
      if (agen < longint'(p.lifetime)) begin
        r.alive = 1'b1;
        for (int i = 0; i < 3; i++) begin
          v = clamp32(longint'($signed(vin[i]))
                      + floor_shift(longint'(grav[i]) * longint'(p.dt), 16));
          q = clamp32(longint'($signed(pin[i])) + floor_shift(v * longint'(p.dt), 16));
          vo[i] = v[31:0];
          po[i] = q[31:0];
        end
        t = (agen << 16) / longint'(p.lifetime);
        r.ratio = t[15:0];
        for (int c = 0; c < 4; c++) begin
          v = mix(longint'(col_start[8*c +: 8]), longint'(col_end[8*c +: 8]), t);
          r.color[8*c +: 8] = v[7:0];
        end
        v = mix(longint'(sz_start), longint'(sz_end), t);
        r.size = v[15:0];
      end
    end
    {r.vx, r.vy, r.vz} = {vo[0], vo[1], vo[2]};
    {r.px, r.py, r.pz} = {po[0], po[1], po[2]};
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h", what, got, want);
  endtask

  // Driver: advance on every transfer, idle at random
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || !in_stall) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          particle_t p;
          p = pending_q.pop_front();
          expected_q.push_back(advance_particle(p));
          in_valid <= 1'b1;
          in_alive_in <= p.alive; in_age_in <= p.age; in_lifetime_in <= p.lifetime;
          in_vel_x_in <= p.vx; in_vel_y_in <= p.vy; in_vel_z_in <= p.vz;
          in_pos_x_in <= p.px; in_pos_y_in <= p.py; in_pos_z_in <= p.pz;
          in_delta_time <= p.dt;
        end else
          in_valid <= 1'b0;
      end
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report("unexpected transfer", 32'(out_age_out), 32'd0);
      end else begin
        step_t e;
        e = expected_q.pop_front();
        if (out_alive_out !== e.alive)
          report("alive", 32'(out_alive_out), 32'(e.alive));
        if (out_age_out !== e.age) report("age", 32'(out_age_out), 32'(e.age));
        if (out_vel_x_out !== e.vx) report("vel_x", out_vel_x_out, e.vx);
        if (out_vel_y_out !== e.vy) report("vel_y", out_vel_y_out, e.vy);
        if (out_vel_z_out !== e.vz) report("vel_z", out_vel_z_out, e.vz);
        if (out_pos_x_out !== e.px) report("pos_x", out_pos_x_out, e.px);
        if (out_pos_y_out !== e.py) report("pos_y", out_pos_y_out, e.py);
        if (out_pos_z_out !== e.pz) report("pos_z", out_pos_z_out, e.pz);
        if (out_life_ratio !== e.ratio)
          report("life_ratio", 32'(out_life_ratio), 32'(e.ratio));
        if (out_color_out !== e.color) report("color", out_color_out, e.color);
        if (out_size_out !== e.size) report("size", 32'(out_size_out), 32'(e.size));
      end
    end
  end

  task automatic write_reg(pe_reg_e idx, logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_GRAV_X:      grav[0] = data;
      REG_GRAV_Y:      grav[1] = data;
      REG_GRAV_Z:      grav[2] = data;
      REG_COLOR_START: col_start = data;
      REG_COLOR_END:   col_end = data;
      REG_SIZE_START:  sz_start = data[15:0];
      REG_SIZE_END:    sz_end = data[15:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || expected_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(200000) - 100000;
      default: return $urandom;
    endcase
  endfunction

  function automatic particle_t rnd_particle();
    particle_t p;
    p.alive = ($urandom_range(9) != 0);
    p.lifetime = $urandom_range(4) == 0 ? 31'($urandom) : 31'($urandom_range(20, 1) << 16);
    p.age = $urandom_range(7) == 0 ? 31'($urandom) : 31'($urandom_range(p.lifetime));
    p.dt = $urandom_range(5) == 0 ? 31'($urandom) : 31'($urandom_range(8192));
    {p.vx, p.vy, p.vz} = {rnd_word(), rnd_word(), rnd_word()};
    {p.px, p.py, p.pz} = {rnd_word(), rnd_word(), rnd_word()};
    return p;
  endfunction

  task automatic random_cfg();
    write_reg(REG_GRAV_X, rnd_word());
    write_reg(REG_GRAV_Y, rnd_word());
    write_reg(REG_GRAV_Z, rnd_word());
    write_reg(REG_COLOR_START, $urandom);
    write_reg(REG_COLOR_END, $urandom);
    write_reg(REG_SIZE_START, $urandom_range(16'hFFFF));
    write_reg(REG_SIZE_END, $urandom_range(16'hFFFF));
  endtask

  initial begin
    particle_t p;
    grav = '{32'sd0, -32'sd131072, 32'sd0};
    col_start = 32'hFFFFFFFF; col_end = 32'hFFFFFF00;
    sz_start = 16'd256; sz_end = 16'd128;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: inactive, dying, zero lifetime, saturations, extremes
    p = '{1'b0, 31'h7FFFFFFF, 31'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h1,
          32'hFFFFFFFF, 32'h0, 32'h12345678, 31'h7FFFFFFF};
    pending_q.push_back(p);
    p = '{1'b1, 31'd0, 31'd0, 32'h1, 32'h2, 32'h3, 32'h4, 32'h5, 32'h6, 31'd0};
    pending_q.push_back(p);
    p = '{1'b1, 31'h7FFFFFF0, 31'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h0,
          32'h7FFFFFFF, 32'h80000000, 32'h0, 31'h7FFFFFFF};
    pending_q.push_back(p);
    p = '{1'b1, 31'd0, 31'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF,
          32'h7FFFFFF0, 32'h80000010, 32'h0, 31'h7FFFFFFE};
    pending_q.push_back(p);
    p = '{1'b1, 31'd65536, 31'd131072, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 31'd0};
    pending_q.push_back(p);
    p = '{1'b1, 31'd10, 31'd20, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 31'd10};
    pending_q.push_back(p);
    p = '{1'b1, 31'd0, 31'd1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 31'd0};
    pending_q.push_back(p);
    for (int i = 0; i < 10; i++) pending_q.push_back(rnd_particle());
    drain();
    // Extreme register settings
    write_reg(REG_GRAV_X, 32'h7FFFFFFF); write_reg(REG_GRAV_Y, 32'h80000000);
    write_reg(REG_GRAV_Z, 32'hFFFFFFFF); write_reg(REG_COLOR_START, 32'h00FF00FF);
    write_reg(REG_COLOR_END, 32'hFF00FF00); write_reg(REG_SIZE_START, 32'h0);
    write_reg(REG_SIZE_END, 32'hFFFF);
    for (int i = 0; i < 150; i++) pending_q.push_back(rnd_particle());
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin send_idle = 70; recv_idle = 21; end
      if (ph == 4) begin send_idle = 0; recv_idle = 0; end
      random_cfg();
      for (int i = 0; i < 150; i++) pending_q.push_back(rnd_particle());
      drain();
    end
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end
endmodule
